// ===== rtl/jted_pkg.sv =====
// jted_pkg: shared widths, code page values and scan state codes
// for the japanese text encoding detector; no dependencies
`default_nettype none

package jted_pkg;

   localparam int DATA_BITS  = 8;
   localparam int PAGE_BITS  = 3;
   localparam int SCORE_BITS = 16;
   localparam int POS_BITS   = 16;
   localparam int WIN_DEPTH  = 6;

   typedef logic [DATA_BITS-1:0]  data_type;
   typedef logic [PAGE_BITS-1:0]  page_type;
   typedef logic [SCORE_BITS-1:0] score_out_type;
   typedef logic [POS_BITS-1:0]   pos_type;
   typedef logic [1:0]            code2_type;

   // newest byte at index 0
   typedef logic [WIN_DEPTH-1:0][DATA_BITS-1:0] window_type;

   // code pages
   localparam page_type PAGE_UNKNOWN = 3'd0;
   localparam page_type PAGE_UTF8    = 3'd1;
   localparam page_type PAGE_UTF16LE = 3'd2;
   localparam page_type PAGE_UTF16BE = 3'd3;
   localparam page_type PAGE_JIS     = 3'd4;
   localparam page_type PAGE_ASCII   = 3'd5;
   localparam page_type PAGE_SJIS    = 3'd6;
   localparam page_type PAGE_EUCJP   = 3'd7;

   // byte order mark result
   localparam code2_type MARK_NONE    = 2'd0;
   localparam code2_type MARK_UTF8    = 2'd1;
   localparam code2_type MARK_UTF16LE = 2'd2;
   localparam code2_type MARK_UTF16BE = 2'd3;

   // escape sequence result
   localparam code2_type ESC_UNDECIDED = 2'd0;
   localparam code2_type ESC_FOUND     = 2'd1;
   localparam code2_type ESC_RULED_OUT = 2'd2;

   // zero byte parity result
   localparam code2_type WIDE_UNDECIDED = 2'd0;
   localparam code2_type WIDE_LE        = 2'd1;
   localparam code2_type WIDE_BE        = 2'd2;

   // pair scan skip state
   localparam code2_type SKIP_NONE = 2'd0;
   localparam code2_type SKIP_ONE  = 2'd1;
   localparam code2_type SKIP_WAIT = 2'd3;

   localparam data_type ASCII_ESC = 8'h1B;

   localparam pos_type POS_STOP = 16'hFFFE;

endpackage : jted_pkg

`default_nettype wire

// ===== rtl/jted_req_if.sv =====
// jted_req_if: byte channel into the detector, valid/ready handshake
// depends on jted_pkg for the data width
`default_nettype none

interface jted_req_if
   import jted_pkg::*;
   ();

   logic     valid;
   logic     ready;
   data_type data_byte;
   logic     last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface : jted_req_if

`default_nettype wire

// ===== rtl/jted_rsp_if.sv =====
// jted_rsp_if: result channel out of the detector, valid/ready handshake
// depends on jted_pkg for page and score widths
`default_nettype none

interface jted_rsp_if
   import jted_pkg::*;
   ();

   logic          valid;
   logic          ready;
   page_type      code_page;
   score_out_type sjis_score;
   score_out_type utf8_score;
   score_out_type euc_score;

   modport source (output valid, output code_page, output sjis_score,
                   output utf8_score, output euc_score, input ready);
   modport sink   (input valid, input code_page, input sjis_score,
                   input utf8_score, input euc_score, output ready);

endinterface : jted_rsp_if

`default_nettype wire

// ===== rtl/japanese_text_encoding_detector_top.sv =====
// japanese_text_encoding_detector_top: guesses the code page of a byte buffer
// the result beat is registered and valid in the cycle after the beat carrying last_byte
// throughput: one byte per cycle while req ready is high
// req ready drops only while a result beat is held and rsp ready is low
// reset (synchronous, active high) clears all scan state and empties the result
// register; scan state also returns to reset after each final byte
`default_nettype none

module japanese_text_encoding_detector_top
   import jted_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  wire        clock,
   input  wire        reset,
   jted_req_if.sink   req_chan,
   jted_rsp_if.source rsp_chan
);

   typedef logic [COUNT_BITS-1:0] count_type;

   // one scan step: next skip state and how much to add to the score
   typedef struct packed {
      code2_type  skip;
      logic [1:0] add;
   } scan_type;

   localparam count_type COUNT_CAP = {COUNT_BITS{1'b1}};

   // ------------------------------------------------------------------
   // range helper
   // ------------------------------------------------------------------
   function automatic logic in_rng(input data_type v, input data_type lo,
                                   input data_type hi);
      return (v >= lo) && (v <= hi);
   endfunction

   // saturating add of a small amount
   function automatic count_type sat_add(input count_type s, input logic [1:0] amt);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, s} + {{(COUNT_BITS-1){1'b0}}, amt};
      if (sum > {1'b0, COUNT_CAP}) begin
         return COUNT_CAP;
      end
      return sum[COUNT_BITS-1:0];
   endfunction

   // escape sequence that ended on the previous byte (w is the old window)
   function automatic logic esc_match(input window_type w, input pos_type pos);
      logic three;
      logic six;
      logic four;
      three = (pos >= POS_BITS'(3)) && (w[2] == ASCII_ESC) &&
              (((w[1] == 8'h28) && ((w[0] == 8'h42) || (w[0] == 8'h4A) ||
                                    (w[0] == 8'h49))) ||
               ((w[1] == 8'h24) && ((w[0] == 8'h40) || (w[0] == 8'h42))));
      six   = (pos >= POS_BITS'(6)) && (w[5] == ASCII_ESC) && (w[4] == 8'h26) &&
              (w[3] == 8'h40) && (w[2] == ASCII_ESC) && (w[1] == 8'h24) &&
              (w[0] == 8'h42);
      four  = (pos >= POS_BITS'(4)) && (w[3] == ASCII_ESC) && (w[2] == 8'h24) &&
              (w[1] == 8'h28) && (w[0] == 8'h44);
      return three || six || four;
   endfunction

   // shift-jis pair scan
   function automatic scan_type scan_sjis(input code2_type skip, input data_type a,
                                          input data_type b);
      scan_type r;
      r = '{skip: SKIP_NONE, add: 2'd0};
      if (skip == SKIP_NONE) begin
         if ((in_rng(a, 8'h81, 8'h9F) || in_rng(a, 8'hE0, 8'hFC)) &&
             (in_rng(b, 8'h40, 8'h7E) || in_rng(b, 8'h80, 8'hFC))) begin
            r = '{skip: SKIP_ONE, add: 2'd2};
         end
      end
      return r;
   endfunction

   // utf-8 sequence scan
   function automatic scan_type scan_utf8(input code2_type skip, input data_type a,
                                          input data_type b);
      scan_type r;
      logic     eval;
      r    = '{skip: SKIP_NONE, add: 2'd0};
      eval = 1'b0;
      priority if (skip == SKIP_WAIT) begin
         if (in_rng(b, 8'h80, 8'hBF)) begin
            r = '{skip: SKIP_ONE, add: 2'd3};
         end else begin
            eval = 1'b1;
         end
      end else if (skip == SKIP_NONE) begin
         eval = 1'b1;
      end else begin
         eval = 1'b0;
      end
      if (eval) begin
         priority if (in_rng(a, 8'hC0, 8'hDF) && in_rng(b, 8'h80, 8'hBF)) begin
            r = '{skip: SKIP_ONE, add: 2'd2};
         end else if (in_rng(a, 8'hE0, 8'hEF) && in_rng(b, 8'h80, 8'hBF)) begin
            r = '{skip: SKIP_WAIT, add: 2'd0};
         end else begin
            r = '{skip: SKIP_NONE, add: 2'd0};
         end
      end
      return r;
   endfunction

   // euc-jp sequence scan
   function automatic scan_type scan_euc(input code2_type skip, input data_type a,
                                         input data_type b);
      scan_type r;
      logic     eval;
      r    = '{skip: SKIP_NONE, add: 2'd0};
      eval = 1'b0;
      priority if (skip == SKIP_WAIT) begin
         if (in_rng(b, 8'hA1, 8'hFE)) begin
            r = '{skip: SKIP_ONE, add: 2'd3};
         end else begin
            eval = 1'b1;
         end
      end else if (skip == SKIP_NONE) begin
         eval = 1'b1;
      end else begin
         eval = 1'b0;
      end
      if (eval) begin
         priority if ((in_rng(a, 8'hA1, 8'hFE) && in_rng(b, 8'hA1, 8'hFE)) ||
                      ((a == 8'h8E) && in_rng(b, 8'hA1, 8'hDF))) begin
            r = '{skip: SKIP_ONE, add: 2'd2};
         end else if ((a == 8'h8F) && in_rng(b, 8'hA1, 8'hFE)) begin
            r = '{skip: SKIP_WAIT, add: 2'd0};
         end else begin
            r = '{skip: SKIP_NONE, add: 2'd0};
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // scan state
   // ------------------------------------------------------------------
   window_type win_ff,   win_in;
   pos_type    pos_ff,   pos_in;
   code2_type  mark_ff,  mark_in;
   code2_type  esc_ff,   esc_in;
   code2_type  wide_ff,  wide_in;
   logic       plain_ff, plain_in;
   code2_type  skip_sjis_ff, skip_sjis_in;
   code2_type  skip_utf8_ff, skip_utf8_in;
   code2_type  skip_euc_ff,  skip_euc_in;
   count_type  sc_sjis_ff, sc_sjis_in;
   count_type  sc_utf8_ff, sc_utf8_in;
   count_type  sc_euc_ff,  sc_euc_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   page_type      page_ff,      page_in;
   score_out_type out_sjis_ff,  out_sjis_in;
   score_out_type out_utf8_ff,  out_utf8_in;
   score_out_type out_euc_ff,   out_euc_in;

   // values after this byte, before the end-of-buffer clear
   code2_type mark_nx;
   code2_type esc_nx;
   code2_type wide_nx;
   logic      plain_nx;
   count_type sc_sjis_nx;
   count_type sc_utf8_nx;
   count_type sc_euc_nx;
   scan_type  st_sjis;
   scan_type  st_utf8;
   scan_type  st_euc;
   page_type  page_nx;

   data_type  cur_b;
   data_type  prev_a;
   logic      accept;
   logic      pair_ok;

   // input is taken whenever the result register is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign cur_b   = req_chan.data_byte;
   assign prev_a  = win_ff[0];
   assign pair_ok = (pos_ff != '0);

   assign st_sjis = scan_sjis(skip_sjis_ff, prev_a, cur_b);
   assign st_utf8 = scan_utf8(skip_utf8_ff, prev_a, cur_b);
   assign st_euc  = scan_euc(skip_euc_ff, prev_a, cur_b);

   always_comb begin
      // byte order mark, only at the very start of the buffer
      mark_nx = mark_ff;
      if (mark_ff == MARK_NONE) begin
         priority if ((pos_ff == POS_BITS'(1)) && (prev_a == 8'hFF) &&
                      (cur_b == 8'hFE)) begin
            mark_nx = MARK_UTF16LE;
         end else if ((pos_ff == POS_BITS'(1)) && (prev_a == 8'hFE) &&
                      (cur_b == 8'hFF)) begin
            mark_nx = MARK_UTF16BE;
         end else if ((pos_ff == POS_BITS'(2)) && (win_ff[1] == 8'hEF) &&
                      (prev_a == 8'hBB) && (cur_b == 8'hBF)) begin
            mark_nx = MARK_UTF8;
         end else begin
            mark_nx = MARK_NONE;
         end
      end

      // iso-2022-jp escape, counted only once a byte follows it
      esc_nx = esc_ff;
      if (esc_ff == ESC_UNDECIDED) begin
         priority if (esc_match(win_ff, pos_ff)) begin
            esc_nx = ESC_FOUND;
         end else if (cur_b[7]) begin
            esc_nx = ESC_RULED_OUT;
         end else begin
            esc_nx = ESC_UNDECIDED;
         end
      end

      // first zero byte followed by a 7-bit byte sets the utf-16 order
      wide_nx = wide_ff;
      if ((wide_ff == WIDE_UNDECIDED) && pair_ok && (prev_a == 8'h00) && !cur_b[7]) begin
         // zero byte at odd position means little endian
         wide_nx = pos_ff[0] ? WIDE_BE : WIDE_LE;
      end

      plain_nx = plain_ff && !((cur_b == ASCII_ESC) || cur_b[7]);

      sc_sjis_nx   = sc_sjis_ff;
      sc_utf8_nx   = sc_utf8_ff;
      sc_euc_nx    = sc_euc_ff;
      skip_sjis_in = skip_sjis_ff;
      skip_utf8_in = skip_utf8_ff;
      skip_euc_in  = skip_euc_ff;
      if (pair_ok) begin
         sc_sjis_nx   = (st_sjis.add != 2'd0) ? sat_add(sc_sjis_ff, st_sjis.add)
                                              : sc_sjis_ff;
         sc_utf8_nx   = (st_utf8.add != 2'd0) ? sat_add(sc_utf8_ff, st_utf8.add)
                                              : sc_utf8_ff;
         sc_euc_nx    = (st_euc.add != 2'd0)  ? sat_add(sc_euc_ff, st_euc.add)
                                              : sc_euc_ff;
         skip_sjis_in = st_sjis.skip;
         skip_utf8_in = st_utf8.skip;
         skip_euc_in  = st_euc.skip;
      end

      // verdict in priority order, scores need a strict winner
      priority if (mark_nx == MARK_UTF8) begin
         page_nx = PAGE_UTF8;
      end else if (mark_nx == MARK_UTF16LE) begin
         page_nx = PAGE_UTF16LE;
      end else if (mark_nx == MARK_UTF16BE) begin
         page_nx = PAGE_UTF16BE;
      end else if (esc_nx == ESC_FOUND) begin
         page_nx = PAGE_JIS;
      end else if (wide_nx == WIDE_LE) begin
         page_nx = PAGE_UTF16LE;
      end else if (wide_nx == WIDE_BE) begin
         page_nx = PAGE_UTF16BE;
      end else if (plain_nx) begin
         page_nx = PAGE_ASCII;
      end else if ((sc_sjis_nx > sc_euc_nx) && (sc_sjis_nx > sc_utf8_nx)) begin
         page_nx = PAGE_SJIS;
      end else if ((sc_utf8_nx > sc_euc_nx) && (sc_utf8_nx > sc_sjis_nx)) begin
         page_nx = PAGE_UTF8;
      end else if ((sc_euc_nx > sc_sjis_nx) && (sc_euc_nx > sc_utf8_nx)) begin
         page_nx = PAGE_EUCJP;
      end else begin
         page_nx = PAGE_UNKNOWN;
      end
   end

   // state commit: hold when idle, clear after the final byte
   always_comb begin
      win_in     = win_ff;
      pos_in     = pos_ff;
      mark_in    = mark_ff;
      esc_in     = esc_ff;
      wide_in    = wide_ff;
      plain_in   = plain_ff;
      sc_sjis_in = sc_sjis_ff;
      sc_utf8_in = sc_utf8_ff;
      sc_euc_in  = sc_euc_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            win_in     = '0;
            pos_in     = '0;
            mark_in    = MARK_NONE;
            esc_in     = ESC_UNDECIDED;
            wide_in    = WIDE_UNDECIDED;
            plain_in   = 1'b1;
            sc_sjis_in = '0;
            sc_utf8_in = '0;
            sc_euc_in  = '0;
         end else begin
            win_in     = {win_ff[WIN_DEPTH-2:0], cur_b};
            // position parks on the top two values, keeping its parity
            pos_in     = (pos_ff < POS_STOP) ? pos_ff + POS_BITS'(1)
                                             : (pos_ff ^ POS_BITS'(1));
            mark_in    = mark_nx;
            esc_in     = esc_nx;
            wide_in    = wide_nx;
            plain_in   = plain_nx;
            sc_sjis_in = sc_sjis_nx;
            sc_utf8_in = sc_utf8_nx;
            sc_euc_in  = sc_euc_nx;
         end
      end
   end

   // skip state: scan value on a mid-buffer byte, cleared at the end
   code2_type skip_sjis_q, skip_utf8_q, skip_euc_q;
   always_comb begin
      skip_sjis_q = skip_sjis_ff;
      skip_utf8_q = skip_utf8_ff;
      skip_euc_q  = skip_euc_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            skip_sjis_q = SKIP_NONE;
            skip_utf8_q = SKIP_NONE;
            skip_euc_q  = SKIP_NONE;
         end else begin
            skip_sjis_q = skip_sjis_in;
            skip_utf8_q = skip_utf8_in;
            skip_euc_q  = skip_euc_in;
         end
      end
   end

   // result register, loaded on the final byte, freed when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      page_in      = page_ff;
      out_sjis_in  = out_sjis_ff;
      out_utf8_in  = out_utf8_ff;
      out_euc_in   = out_euc_ff;
      if (accept && req_chan.last_byte) begin
         rsp_valid_in = 1'b1;
         page_in      = page_nx;
         out_sjis_in  = SCORE_BITS'(sc_sjis_nx);
         out_utf8_in  = SCORE_BITS'(sc_utf8_nx);
         out_euc_in   = SCORE_BITS'(sc_euc_nx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         pos_ff       <= '0;
         mark_ff      <= MARK_NONE;
         esc_ff       <= ESC_UNDECIDED;
         wide_ff      <= WIDE_UNDECIDED;
         plain_ff     <= 1'b1;
         skip_sjis_ff <= SKIP_NONE;
         skip_utf8_ff <= SKIP_NONE;
         skip_euc_ff  <= SKIP_NONE;
         sc_sjis_ff   <= '0;
         sc_utf8_ff   <= '0;
         sc_euc_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         pos_ff       <= pos_in;
         mark_ff      <= mark_in;
         esc_ff       <= esc_in;
         wide_ff      <= wide_in;
         plain_ff     <= plain_in;
         skip_sjis_ff <= skip_sjis_q;
         skip_utf8_ff <= skip_utf8_q;
         skip_euc_ff  <= skip_euc_q;
         sc_sjis_ff   <= sc_sjis_in;
         sc_utf8_ff   <= sc_utf8_in;
         sc_euc_ff    <= sc_euc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      out_sjis_ff <= out_sjis_in;
      out_utf8_ff <= out_utf8_in;
      out_euc_ff  <= out_euc_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.code_page  = page_ff;
   assign rsp_chan.sjis_score = out_sjis_ff;
   assign rsp_chan.utf8_score = out_utf8_ff;
   assign rsp_chan.euc_score  = out_euc_ff;

`ifndef ASSERT_OFF
   // a final byte always yields a result beat next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.last_byte) |=> rsp_chan.valid)
      else $error("final byte did not produce a result beat");

   // scan state is back at its start after a final byte
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.last_byte) |=>
         ((pos_ff == '0) && plain_ff && (sc_sjis_ff == '0) && (sc_euc_ff == '0)))
      else $error("scan state not cleared after final byte");

   // plain ascii buffers can never have scored a pair
   a_ascii_no_score: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.code_page == PAGE_ASCII)) |->
         ((rsp_chan.sjis_score == '0) && (rsp_chan.utf8_score == '0) &&
          (rsp_chan.euc_score == '0)))
      else $error("ascii verdict with non-zero scores");

   // shift-jis scan never waits for a third byte
   a_sjis_skip: assert property (@(posedge clock) disable iff (reset)
      skip_sjis_ff != SKIP_WAIT)
      else $error("shift-jis skip state out of range");

   // a held result beat blocks no byte only when it is being drained
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !accept)
      else $error("byte accepted over a held result beat");
`endif

endmodule : japanese_text_encoding_detector_top

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for japanese_text_encoding_detector_top, with a
// byte-level code page predictor, a queue-fed driver and a result monitor
// depends on jted_pkg, jted_req_if, jted_rsp_if and the detector rtl
`timescale 1ns / 100ps

module tb_top;
   import jted_pkg::*;

   localparam int          COUNT_W      = 16;
   localparam int          RANDOM_BYTES = 750;
   localparam int          TAIL_CALM    = 100;
   localparam int unsigned LIMIT_CYCLES = 3_000_000;
   localparam logic [COUNT_W-1:0] SCORE_CAP = '1;

   // score slots, one per pair scan
   localparam int SC_SJIS = 0;
   localparam int SC_UTF8 = 1;
   localparam int SC_EUC  = 2;

   // flavours of generated text
   typedef enum int {
      TXT_ASCII, TXT_SJIS, TXT_UTF8, TXT_EUC,
      TXT_UTF16LE, TXT_UTF16BE, TXT_JIS, TXT_NOISE
   } text_kind_e;

   typedef struct {
      data_type data_byte;
      logic     last_byte;
      logic     drain_first;  // hold this beat back until all verdicts are in
   } byte_beat_t;

   typedef struct {
      page_type      code_page;
      score_out_type sjis_score;
      score_out_type utf8_score;
      score_out_type euc_score;
   } verdict_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jted_req_if req_chan ();
   jted_rsp_if rsp_chan ();

   japanese_text_encoding_detector_top #(.COUNT_BITS(COUNT_W)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor state: a private copy of everything the detector tracks
   // ---------------------------------------------------------------------
   data_type           recent [7];      // newest byte at index 0
   pos_type            byte_pos;
   code2_type          mark_seen;
   code2_type          escape_seen;
   code2_type          wide_seen;
   logic               plain_only;
   code2_type          scan_skip [3];
   logic [COUNT_W-1:0] scan_score [3];

   // iso-2022-jp escape sequences, byte j of sequence i in esc_pat[i][j]
   logic [5:0][7:0] esc_pat [7];
   int              esc_len [7];

   verdict_t   verdicts [$];     // expected result beats, oldest first
   byte_beat_t byte_queue [$];   // beats still to be driven
   data_type   text [$];         // buffer under construction

   int unsigned cycle_count = 0;
   int          mismatch_count = 0;
   logic        req_took = 1'b0;
   logic        calm_tail = 1'b0;

   // driver and receiver pacing
   byte_beat_t next_beat;
   int         req_gap = 0;
   int         req_seg = 0;
   logic       req_busy = 1'b0;
   int         rsp_stall = 0;
   int         rsp_seg = 0;
   logic       rsp_busy = 1'b0;

   function automatic logic in_band(input data_type v, input data_type lo,
                                    input data_type hi);
      return (v >= lo) && (v <= hi);
   endfunction

   // back to the state the detector holds after reset and after each final beat
   task automatic clear_detector();
      foreach (recent[i]) recent[i] = '0;
      byte_pos    = '0;
      mark_seen   = MARK_NONE;
      escape_seen = ESC_UNDECIDED;
      wide_seen   = WIDE_UNDECIDED;
      plain_only  = 1'b1;
      foreach (scan_skip[k]) scan_skip[k] = SKIP_NONE;
      foreach (scan_score[k]) scan_score[k] = '0;
   endtask

   task automatic bump_score(input int k, input int amount);
      logic [COUNT_W:0] sum;
      sum = {1'b0, scan_score[k]} + (COUNT_W+1)'(amount);
      // saturate rather than wrap
      scan_score[k] = (sum > {1'b0, SCORE_CAP}) ? SCORE_CAP : sum[COUNT_W-1:0];
   endtask

   // one pair scan: two = two-byte match, start3 = first two of a three-byte
   // sequence, cont = newest byte completes a pending three-byte sequence
   task automatic scan_step(input int k, input logic two, input logic start3,
                            input logic cont);
      logic go;
      go = 1'b1;
      if (scan_skip[k] == SKIP_WAIT) begin
         if (cont) begin
            bump_score(k, 3);
            scan_skip[k] = SKIP_ONE;
            go = 1'b0;
         end else begin
            scan_skip[k] = SKIP_NONE;
         end
      end else if (scan_skip[k] != SKIP_NONE) begin
         scan_skip[k] = SKIP_NONE;
         go = 1'b0;
      end
      if (go) begin
         if (two) begin
            bump_score(k, 2);
            scan_skip[k] = SKIP_ONE;
         end else if (start3) begin
            scan_skip[k] = SKIP_WAIT;
         end
      end
   endtask

   // advance the predictor by one accepted byte; a final byte queues a verdict
   task automatic detect_step(input data_type b, input logic last);
      data_type      a;
      logic          hit;
      logic          ok;
      verdict_t      v;
      score_out_type s;
      score_out_type u;
      score_out_type e;
      for (int k = 6; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
      a = recent[1];

      // byte order mark, only at the very start of the buffer
      if (mark_seen == MARK_NONE) begin
         if (byte_pos == 1 && a == 8'hFF && b == 8'hFE)
            mark_seen = MARK_UTF16LE;
         else if (byte_pos == 1 && a == 8'hFE && b == 8'hFF)
            mark_seen = MARK_UTF16BE;
         else if (byte_pos == 2 && recent[2] == 8'hEF && a == 8'hBB && b == 8'hBF)
            mark_seen = MARK_UTF8;
      end

      // an escape counts only once a further byte has followed it
      if (escape_seen == ESC_UNDECIDED) begin
         hit = 1'b0;
         for (int i = 0; i < 7; i++) begin
            ok = (byte_pos >= esc_len[i]);
            for (int j = 0; j < esc_len[i]; j++)
               if (recent[esc_len[i] - j] != esc_pat[i][j]) ok = 1'b0;
            hit = hit | ok;
         end
         if (hit) escape_seen = ESC_FOUND;
         else if (b > 8'h7F) escape_seen = ESC_RULED_OUT;
      end

      // first zero byte followed by a 7-bit byte fixes the utf-16 byte order
      if (wide_seen == WIDE_UNDECIDED && byte_pos >= 1 && a == 8'h00 && b <= 8'h7F)
         wide_seen = ((byte_pos - 1'b1) & 1) ? WIDE_LE : WIDE_BE;

      if (b == ASCII_ESC || b >= 8'h80) plain_only = 1'b0;

      if (byte_pos >= 1) begin
         scan_step(SC_SJIS,
                   (in_band(a, 8'h81, 8'h9F) || in_band(a, 8'hE0, 8'hFC)) &&
                   (in_band(b, 8'h40, 8'h7E) || in_band(b, 8'h80, 8'hFC)),
                   1'b0, 1'b0);
         scan_step(SC_UTF8,
                   in_band(a, 8'hC0, 8'hDF) && in_band(b, 8'h80, 8'hBF),
                   in_band(a, 8'hE0, 8'hEF) && in_band(b, 8'h80, 8'hBF),
                   in_band(b, 8'h80, 8'hBF));
         scan_step(SC_EUC,
                   (in_band(a, 8'hA1, 8'hFE) && in_band(b, 8'hA1, 8'hFE)) ||
                   (a == 8'h8E && in_band(b, 8'hA1, 8'hDF)),
                   a == 8'h8F && in_band(b, 8'hA1, 8'hFE),
                   in_band(b, 8'hA1, 8'hFE));
      end

      // position sticks at the top two values, keeping its parity right
      if (byte_pos < POS_STOP) byte_pos = byte_pos + 1'b1;
      else byte_pos = byte_pos ^ pos_type'(1);

      if (last) begin
         s = score_out_type'(scan_score[SC_SJIS]);
         u = score_out_type'(scan_score[SC_UTF8]);
         e = score_out_type'(scan_score[SC_EUC]);
         if (mark_seen == MARK_UTF8) v.code_page = PAGE_UTF8;
         else if (mark_seen == MARK_UTF16LE) v.code_page = PAGE_UTF16LE;
         else if (mark_seen == MARK_UTF16BE) v.code_page = PAGE_UTF16BE;
         else if (escape_seen == ESC_FOUND) v.code_page = PAGE_JIS;
         else if (wide_seen == WIDE_LE) v.code_page = PAGE_UTF16LE;
         else if (wide_seen == WIDE_BE) v.code_page = PAGE_UTF16BE;
         else if (plain_only) v.code_page = PAGE_ASCII;
         // scores use the full counter width, strict maximum wins
         else if (scan_score[SC_SJIS] > scan_score[SC_EUC] &&
                  scan_score[SC_SJIS] > scan_score[SC_UTF8]) v.code_page = PAGE_SJIS;
         else if (scan_score[SC_UTF8] > scan_score[SC_EUC] &&
                  scan_score[SC_UTF8] > scan_score[SC_SJIS]) v.code_page = PAGE_UTF8;
         else if (scan_score[SC_EUC] > scan_score[SC_SJIS] &&
                  scan_score[SC_EUC] > scan_score[SC_UTF8]) v.code_page = PAGE_EUCJP;
         else v.code_page = PAGE_UNKNOWN;
         v.sjis_score = s;
         v.utf8_score = u;
         v.euc_score  = e;
         verdicts.push_back(v);
         clear_detector();
      end
   endtask

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_text(input logic drain);
      byte_beat_t bt;
      foreach (text[i]) begin
         bt.data_byte   = text[i];
         bt.last_byte   = (i == text.size() - 1);
         bt.drain_first = drain && (i == 0);
         byte_queue.push_back(bt);
      end
   endtask

   // append one character of the given flavour to the buffer
   task automatic add_unit(input text_kind_e kind);
      int       pick;
      int       n;
      data_type c;
      pick = $urandom_range(0, 4);
      c = data_type'($urandom_range(8'h20, 8'h7E));
      case (kind)
         TXT_SJIS: begin
            if (pick == 0) begin
               text.push_back(c);
            end else begin
               text.push_back(pick[0] ? data_type'($urandom_range(8'h81, 8'h9F))
                                      : data_type'($urandom_range(8'hE0, 8'hFC)));
               text.push_back($urandom_range(0, 1) ? data_type'($urandom_range(8'h40, 8'h7E))
                                                   : data_type'($urandom_range(8'h80, 8'hFC)));
            end
         end
         TXT_UTF8: begin
            if (pick == 0) begin
               text.push_back(c);
            end else if (pick == 1) begin
               text.push_back(data_type'($urandom_range(8'hC0, 8'hDF)));
               text.push_back(data_type'($urandom_range(8'h80, 8'hBF)));
            end else begin
               text.push_back(data_type'($urandom_range(8'hE0, 8'hEF)));
               text.push_back(data_type'($urandom_range(8'h80, 8'hBF)));
               text.push_back(data_type'($urandom_range(8'h80, 8'hBF)));
            end
         end
         TXT_EUC: begin
            if (pick == 0) begin
               text.push_back(c);
            end else if (pick == 1) begin
               // half-width kana
               text.push_back(8'h8E);
               text.push_back(data_type'($urandom_range(8'hA1, 8'hDF)));
            end else if (pick == 2) begin
               // supplementary plane, three bytes
               text.push_back(8'h8F);
               text.push_back(data_type'($urandom_range(8'hA1, 8'hFE)));
               text.push_back(data_type'($urandom_range(8'hA1, 8'hFE)));
            end else begin
               text.push_back(data_type'($urandom_range(8'hA1, 8'hFE)));
               text.push_back(data_type'($urandom_range(8'hA1, 8'hFE)));
            end
         end
         TXT_UTF16LE: begin
            if (pick < 3) begin
               text.push_back(c);
               text.push_back(8'h00);
            end else begin
               text.push_back(data_type'($urandom_range(0, 255)));
               text.push_back(8'h30);
            end
         end
         TXT_UTF16BE: begin
            if (pick < 3) begin
               text.push_back(8'h00);
               text.push_back(c);
            end else begin
               text.push_back(8'h30);
               text.push_back(data_type'($urandom_range(0, 255)));
            end
         end
         TXT_JIS: begin
            if (pick == 0) begin
               text.push_back(c);
            end else if (pick == 1) begin
               n = $urandom_range(0, 6);
               for (int j = 0; j < esc_len[n]; j++) text.push_back(esc_pat[n][j]);
            end else begin
               text.push_back(data_type'($urandom_range(8'h21, 8'h7E)));
               text.push_back(data_type'($urandom_range(8'h21, 8'h7E)));
            end
         end
         TXT_ASCII: text.push_back(data_type'($urandom_range(0, 8'h7F)));
         default:   text.push_back(data_type'($urandom_range(0, 255)));
      endcase
   endtask

   // ---------------------------------------------------------------------
   // driver: bytes change on the falling edge, gaps come in short bursts
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_took) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (byte_queue.size() == 0 ||
                      (byte_queue[0].drain_first && verdicts.size() != 0)) begin
            // nothing left, or waiting for the pipe to run dry
            req_chan.valid <= 1'b0;
         end else begin
            next_beat = byte_queue.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.data_byte <= next_beat.data_byte;
            req_chan.last_byte <= next_beat.last_byte;
            // alternate busy and quiet stretches
            if (req_seg == 0) begin
               req_busy = ($urandom_range(0, 2) != 0);
               req_seg  = $urandom_range(16, 160);
            end
            req_seg = req_seg - 1;
            if (!calm_tail && req_busy && $urandom_range(0, 5) == 0)
               req_gap = $urandom_range(1, 7);
         end
      end
   end

   // receiver: back-pressure bursts on the result channel
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (rsp_seg == 0) begin
            rsp_busy = ($urandom_range(0, 2) != 0);
            rsp_seg  = $urandom_range(16, 160);
         end
         rsp_seg = rsp_seg - 1;
         if (!calm_tail && rsp_busy && $urandom_range(0, 7) == 0)
            rsp_stall = $urandom_range(1, 7);
      end
   end

   // ---------------------------------------------------------------------
   // monitor: results are checked before the same edge's byte is predicted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_t want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (verdicts.size() == 0) begin
               flag_mismatch("result beat with nothing expected");
            end else begin
               want = verdicts.pop_front();
               if (rsp_chan.code_page !== want.code_page)
                  flag_mismatch($sformatf("code_page got %0d want %0d",
                                          rsp_chan.code_page, want.code_page));
               if (rsp_chan.sjis_score !== want.sjis_score)
                  flag_mismatch($sformatf("sjis_score got %0d want %0d",
                                          rsp_chan.sjis_score, want.sjis_score));
               if (rsp_chan.utf8_score !== want.utf8_score)
                  flag_mismatch($sformatf("utf8_score got %0d want %0d",
                                          rsp_chan.utf8_score, want.utf8_score));
               if (rsp_chan.euc_score !== want.euc_score)
                  flag_mismatch($sformatf("euc_score got %0d want %0d",
                                          rsp_chan.euc_score, want.euc_score));
            end
         end
         req_took <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready)
            detect_step(req_chan.data_byte, req_chan.last_byte);
         calm_tail <= (byte_queue.size() <= TAIL_CALM);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      text_kind_e kind;
      int         units;
      int         random_bytes;

      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;

      esc_pat[0] = {8'h00, 8'h00, 8'h00, 8'h42, 8'h28, 8'h1B};  esc_len[0] = 3;
      esc_pat[1] = {8'h00, 8'h00, 8'h00, 8'h4A, 8'h28, 8'h1B};  esc_len[1] = 3;
      esc_pat[2] = {8'h00, 8'h00, 8'h00, 8'h49, 8'h28, 8'h1B};  esc_len[2] = 3;
      esc_pat[3] = {8'h00, 8'h00, 8'h00, 8'h40, 8'h24, 8'h1B};  esc_len[3] = 3;
      esc_pat[4] = {8'h00, 8'h00, 8'h00, 8'h42, 8'h24, 8'h1B};  esc_len[4] = 3;
      esc_pat[5] = {8'h42, 8'h24, 8'h1B, 8'h40, 8'h26, 8'h1B};  esc_len[5] = 6;
      esc_pat[6] = {8'h00, 8'h00, 8'h44, 8'h28, 8'h24, 8'h1B};  esc_len[6] = 4;
      clear_detector();

      // directed buffers
      text = '{8'h00};                         queue_text(1'b0);  // single byte, plain
      text = '{8'hFF};                         queue_text(1'b0);  // single high byte
      text = '{8'hFF, 8'hFE};                  queue_text(1'b0);  // le mark
      text = '{8'hFE, 8'hFF};                  queue_text(1'b0);  // be mark
      text = '{8'hEF, 8'hBB, 8'hBF};           queue_text(1'b0);  // utf-8 mark
      text = '{8'h1B, 8'h28, 8'h42, 8'h41};    queue_text(1'b1);  // escape then a byte
      text = '{8'h1B, 8'h24, 8'h42};           queue_text(1'b0);  // escape cut at the end
      text = '{8'h41, 8'h00, 8'h42};           queue_text(1'b0);  // zero at odd position
      text = '{8'h81, 8'h40};                  queue_text(1'b0);  // shift-jis pair
      text = '{8'hE3, 8'h81, 8'h82};           queue_text(1'b0);  // utf-8 three bytes
      text = '{8'h8F, 8'hA1};                  queue_text(1'b0);  // euc three-byte cut off

      // random buffers, mostly well-formed text of one flavour
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         text.delete();
         kind = text_kind_e'($urandom_range(0, 7));
         if ($urandom_range(0, 2) == 0) begin
            case (kind)
               TXT_UTF8:    text = '{8'hEF, 8'hBB, 8'hBF};
               TXT_UTF16LE: text = '{8'hFF, 8'hFE};
               TXT_UTF16BE: text = '{8'hFE, 8'hFF};
               default:     ;
            endcase
         end
         units = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         repeat (units)
            add_unit(($urandom_range(0, 11) == 0) ? text_kind_e'($urandom_range(0, 7)) : kind);
         // broken buffers: cut short or one byte trashed
         if ($urandom_range(0, 7) == 0 && text.size() > 1)
            void'(text.pop_back());
         else if ($urandom_range(0, 7) == 0)
            text[$urandom_range(0, text.size() - 1)] = data_type'($urandom_range(0, 255));
         random_bytes += text.size();
         queue_text($urandom_range(0, 19) == 0);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for the queue to empty and every verdict to be matched
      while (byte_queue.size() != 0 || req_chan.valid || verdicts.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule : tb_top
